[rtl/ms_pkg.sv]
// Shared types for the merge sorter: element word and the control/status
// bundles between the top level and the sort core. No dependencies.
package ms_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // requests from the top level into the sort core
    typedef struct packed {
        logic start;     // begin sorting the stored run
        logic load_we;   // write one loaded element into bank A
        logic out_re;    // read one sorted element for output
    } ms_ctrl_t;

    // status from the sort core
    typedef struct packed {
        logic done;      // one-cycle pulse: sorted run is ready
        logic bank;      // bank that holds the sorted run (0 = A, 1 = B)
    } ms_stat_t;

endpackage

[rtl/ms_core.sv]
// Sort core: two element banks used ping-pong and one shared compare unit
// stepped through bottom-up merge passes by a small sequencer. Uses ms_pkg.
module ms_core import ms_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  ms_ctrl_t      ctrl,
    input  logic [AW:0]   n,          // run length, valid with ctrl.start
    input  logic [AW-1:0] load_addr,
    input  data_t         load_data,
    input  logic [AW-1:0] out_addr,
    output data_t         rd_data,
    output ms_stat_t      stat
);

    // wide enough for lo + 2*width while width < n <= DEPTH
    localparam int CW = AW + 2;

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_RD, C_WR} state_t;

    state_t        st_reg;
    logic [CW-1:0] n_reg, width_reg, lo_reg, mid_reg, hi_reg;
    logic [CW-1:0] i_reg, j_reg, k_reg;
    logic          src_reg;
    logic          done_reg;

    data_t bank_a [DEPTH];
    data_t bank_b [DEPTH];
    data_t rd_l_reg, rd_r_reg;

    logic [CW-1:0] width2, lo_w, lo_2w, mid_c, hi_c;
    logic          take_left;
    data_t         merge_data;
    logic          we_a, we_b, rd_en;
    logic [AW-1:0] wa_addr, rd_addr_l, rd_addr_r;
    data_t         wa_data;

    assign width2 = width_reg << 1;
    assign lo_w   = lo_reg + width_reg;
    assign lo_2w  = lo_reg + width2;
    assign mid_c  = (lo_w  > n_reg) ? n_reg : lo_w;
    assign hi_c   = (lo_2w > n_reg) ? n_reg : lo_2w;

    // ties go to the left run
    assign take_left  = (i_reg < mid_reg) &&
                        ((j_reg >= hi_reg) || (rd_l_reg <= rd_r_reg));
    assign merge_data = take_left ? rd_l_reg : rd_r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= C_IDLE;
            src_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (st_reg)
                C_IDLE: begin
                    if (ctrl.start) begin
                        n_reg     <= {1'b0, n};
                        width_reg <= CW'(1);
                        lo_reg    <= '0;
                        src_reg   <= 1'b0;
                        if (n <= (AW+1)'(1)) begin
                            done_reg <= 1'b1;
                        end else begin
                            st_reg <= C_RUN;
                        end
                    end
                end
                C_RUN: begin
                    if (lo_reg >= n_reg) begin
                        // pass complete: swap banks, double the run width
                        src_reg   <= ~src_reg;
                        width_reg <= width2;
                        lo_reg    <= '0;
                        if (width2 >= n_reg) begin
                            done_reg <= 1'b1;
                            st_reg   <= C_IDLE;
                        end
                    end else begin
                        mid_reg <= mid_c;
                        hi_reg  <= hi_c;
                        i_reg   <= lo_reg;
                        j_reg   <= mid_c;
                        k_reg   <= lo_reg;
                        st_reg  <= C_RD;
                    end
                end
                C_RD: begin
                    st_reg <= C_WR;
                end
                C_WR: begin
                    k_reg <= k_reg + CW'(1);
                    if (take_left) begin
                        i_reg <= i_reg + CW'(1);
                    end else begin
                        j_reg <= j_reg + CW'(1);
                    end
                    if (k_reg + CW'(1) == hi_reg) begin
                        lo_reg <= lo_2w;
                        st_reg <= C_RUN;
                    end else begin
                        st_reg <= C_RD;
                    end
                end
                default: begin
                    st_reg <= C_IDLE;
                end
            endcase
        end
    end

    // bank A takes loads and merge output when B is the source
    assign we_a    = ctrl.load_we || ((st_reg == C_WR) && src_reg);
    assign we_b    = (st_reg == C_WR) && !src_reg;
    assign wa_addr = ctrl.load_we ? load_addr : k_reg[AW-1:0];
    assign wa_data = ctrl.load_we ? load_data : merge_data;

    always_ff @(posedge aclk) begin
        if (we_a) begin
            bank_a[wa_addr] <= wa_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (we_b) begin
            bank_b[k_reg[AW-1:0]] <= merge_data;
        end
    end

    assign rd_en     = (st_reg == C_RD) || ctrl.out_re;
    assign rd_addr_l = (st_reg == C_IDLE) ? out_addr : i_reg[AW-1:0];
    assign rd_addr_r = j_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_l_reg <= src_reg ? bank_b[rd_addr_l] : bank_a[rd_addr_l];
            rd_r_reg <= src_reg ? bank_b[rd_addr_r] : bank_a[rd_addr_r];
        end
    end

    assign rd_data   = rd_l_reg;
    assign stat.done = done_reg;
    assign stat.bank = src_reg;

    a_wr_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == C_WR |-> k_reg < hi_reg && k_reg < CW'(DEPTH))
        else $error("merge write outside current run");

    a_rd_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == C_RD |-> i_reg <= mid_reg && j_reg <= hi_reg &&
                           (i_reg < mid_reg || j_reg < hi_reg))
        else $error("merge read pointers out of range");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

endmodule

[rtl/merge_sorter.sv]
// Merge sorter: a run of signed 32-bit values is loaded one request per cycle (tlast closes
// the run); the run is then sorted in bottom-up merge passes with ties kept in input order,
// and sent out ascending with tlast on the final value. A run of N values (N up to DEPTH;
// further values are dropped, their tlast still closes the run) is sorted in ceil(log2 N)
// passes by the one compare unit, which reads two heads and then writes one value; each
// result is read from the bank and then offered on m_tdata until m_tready takes it.
// While sorting and sending, s_tready is low. Depends on ms_pkg and ms_core.
module merge_sorter import ms_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic signed [31:0] s_tdata,  // [31:0] value
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic signed [31:0] m_tdata,  // [31:0] value_res
    output logic              m_tlast
);

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [1:0] {T_LOAD, T_SORT, T_ORD, T_OSEND} state_t;

    state_t        st_reg;
    logic [AW:0]   count_reg;
    logic [AW-1:0] idx_reg, nlast_reg;

    ms_ctrl_t      ctrl;
    ms_stat_t      stat;
    logic          s_acc, room;
    logic [AW:0]   n_next, n_m1;
    data_t         rd_data;

    assign s_acc  = s_tvalid && s_tready;
    assign room   = count_reg < (AW+1)'(DEPTH);
    assign n_next = room ? count_reg + (AW+1)'(1) : count_reg;
    assign n_m1   = n_next - (AW+1)'(1);

    assign ctrl.load_we = s_acc && room;
    assign ctrl.start   = s_acc && s_tlast;
    assign ctrl.out_re  = (st_reg == T_ORD);

    ms_core #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .n         (n_next),
        .load_addr (count_reg[AW-1:0]),
        .load_data (s_tdata),
        .out_addr  (idx_reg),
        .rd_data   (rd_data),
        .stat      (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= T_LOAD;
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            case (st_reg)
                T_LOAD: begin
                    if (s_acc) begin
                        count_reg <= n_next;
                        if (s_tlast) begin
                            nlast_reg <= n_m1[AW-1:0];
                            st_reg    <= T_SORT;
                        end
                    end
                end
                T_SORT: begin
                    if (stat.done) begin
                        idx_reg <= '0;
                        st_reg  <= T_ORD;
                    end
                end
                T_ORD: begin
                    st_reg <= T_OSEND;
                end
                T_OSEND: begin
                    if (m_tready) begin
                        if (idx_reg == nlast_reg) begin
                            count_reg <= '0;
                            st_reg    <= T_LOAD;
                        end else begin
                            idx_reg <= idx_reg + AW'(1);
                            st_reg  <= T_ORD;
                        end
                    end
                end
                default: begin
                    st_reg <= T_LOAD;
                end
            endcase
        end
    end

    assign s_tready = (st_reg == T_LOAD);
    assign m_tvalid = (st_reg == T_OSEND);
    assign m_tdata  = rd_data;
    assign m_tlast  = (idx_reg == nlast_reg);

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (AW+1)'(DEPTH))
        else $error("element count beyond store depth");

    a_sides_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("loading and sending at once");

    a_done_in_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> st_reg == T_SORT)
        else $error("sort done outside sort phase");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> idx_reg <= nlast_reg)
        else $error("output index past end of run");

endmodule

[tb/tb.sv]
// Self-checking bench for merge_sorter: sends runs of signed words and checks each sorted
// result against a bottom-up merge predictor kept in the bench.
// Depends on ms_pkg and the merge_sorter RTL.
`timescale 1ns / 1ps

module tb import ms_pkg::*; ();

    localparam int DEPTH = 64;
    localparam data_t VAL_MAX = 32'sh7FFF_FFFF;
    localparam data_t VAL_MIN = 32'sh8000_0000;

    typedef struct {
        data_t value;
        logic  last;
    } sorted_elem_t;

    logic  aclk;
    logic  aresetn  = 1'b0;
    logic  s_tvalid = 1'b0;
    logic  s_tready;
    data_t s_tdata  = '0;
    logic  s_tlast  = 1'b0;
    logic  m_tvalid;
    logic  m_tready = 1'b0;
    data_t m_tdata;
    logic  m_tlast;

    // bench copy of the block state
    data_t run_store [DEPTH];
    data_t merge_tmp [DEPTH];
    int    run_count;

    sorted_elem_t pending_sorted[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int results_checked;
    int runs_sent;
    int values_dropped;
    int items_stored;

    merge_sorter #(.DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // bottom-up merge passes over the stored run, left run wins ties
    function automatic void sort_run_store(input int n);
        int w;
        int lo;
        int mid;
        int hi;
        int i;
        int j;
        int k;
        for (w = 1; w < n; w = w * 2) begin
            for (lo = 0; lo < n; lo = lo + 2 * w) begin
                mid = (lo + w > n) ? n : lo + w;
                hi  = (lo + 2 * w > n) ? n : lo + 2 * w;
                if (mid < hi) begin
                    i = lo;
                    j = mid;
                    k = lo;
                    while (i < mid && j < hi) begin
                        if (run_store[i] <= run_store[j]) begin
                            merge_tmp[k] = run_store[i];
                            i++;
                        end else begin
                            merge_tmp[k] = run_store[j];
                            j++;
                        end
                        k++;
                    end
                    while (i < mid) begin
                        merge_tmp[k] = run_store[i];
                        i++;
                        k++;
                    end
                    while (j < hi) begin
                        merge_tmp[k] = run_store[j];
                        j++;
                        k++;
                    end
                    for (k = lo; k < hi; k++) begin
                        run_store[k] = merge_tmp[k];
                    end
                end
            end
        end
    endfunction

    function automatic void predict_request(input data_t v, input logic l);
        sorted_elem_t e;
        if (run_count < DEPTH) begin
            run_store[run_count] = v;
            run_count++;
            items_stored++;
        end else begin
            values_dropped++;
        end
        if (l) begin
            sort_run_store(run_count);
            for (int k = 0; k < run_count; k++) begin
                e.value = run_store[k];
                e.last  = (k + 1 == run_count);
                pending_sorted.push_back(e);
            end
            run_count = 0;
            runs_sent++;
        end
    endfunction

    task automatic send_item(input data_t v, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tlast  <= 1'($urandom_range(1));
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        predict_request(v, l);
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // hold the sender until every sorted value has come back
    task automatic wait_drain();
        while (pending_sorted.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_run(input data_t vals[$]);
        for (int k = 0; k < vals.size(); k++) begin
            send_item(vals[k], k == vals.size() - 1);
        end
    endtask

    task automatic test_directed();
        data_t vals[$];
        vals = {VAL_MAX};
        send_run(vals);
        vals = {VAL_MIN, VAL_MAX};
        send_run(vals);
        vals = {VAL_MAX, VAL_MIN, -32'sd1, 32'sd0, 32'sd1, VAL_MIN};
        send_run(vals);
        vals = {32'sd7, 32'sd7, -32'sd3, 32'sd7, -32'sd3};
        send_run(vals);
        vals = {32'sh5555_5555, 32'sh2AAA_AAAA, 32'sd9, 32'sd4, 32'sd0, -32'sd4,
                32'shAAAA_AAAA, VAL_MIN};
        send_run(vals);
        drop_valid();
        wait_drain();
    endtask

    // exactly full store, then runs that spill past it
    task automatic test_store_limits();
        for (int k = 0; k < DEPTH; k++) begin
            send_item($urandom, k == DEPTH - 1);
        end
        for (int k = 0; k < DEPTH + 1; k++) begin
            send_item(data_t'($urandom_range(15)) - 32'sd8, k == DEPTH);
        end
        for (int k = 0; k < DEPTH + 6; k++) begin
            send_item($urandom, k == DEPTH + 5);
        end
        drop_valid();
        wait_drain();
    endtask

    function automatic data_t pick_value(input int style);
        case (style)
            0: return data_t'($urandom_range(8)) - 32'sd4;
            1: begin
                case ($urandom_range(5))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return VAL_MAX - 32'sd1;
                    3: return VAL_MIN + 32'sd1;
                    4: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_runs(input int budget);
        int len;
        int style;
        while (budget > 0) begin
            case ($urandom_range(39))
                0: len = $urandom_range(DEPTH + 8, DEPTH + 1);
                1, 2, 3, 4: len = $urandom_range(DEPTH, 17);
                default: len = $urandom_range(16, 1);
            endcase
            style = $urandom_range(3);
            for (int k = 0; k < len; k++) begin
                send_item(pick_value(style), k == len - 1);
            end
            budget -= (len > DEPTH) ? DEPTH : len;
            if ($urandom_range(7) == 0) begin
                drop_valid();
                wait_drain();
            end
        end
        drop_valid();
        wait_drain();
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        sorted_elem_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sorted.size() == 0) begin
                $error("unexpected result: value_res %0d last_res %0b", m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                e = pending_sorted.pop_front();
                results_checked++;
                if (m_tdata !== e.value) begin
                    $error("value_res: expected %0d, got %0d", e.value, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_res: expected %0b, got %0b", e.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        run_count       = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        mismatch_count  = 0;
        results_checked = 0;
        runs_sent       = 0;
        values_dropped  = 0;
        items_stored    = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_store_limits();

        test_random_runs(45);
        send_idle_pct = 77;
        test_random_runs(45);
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        test_random_runs(45);
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        test_random_runs(45);
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (20) @(posedge aclk);
        if (pending_sorted.size() != 0) begin
            $error("%0d sorted values never arrived", pending_sorted.size());
            mismatch_count++;
        end
        $display("Covered %0d runs with %0d stored values (%0d dropped past a full store).",
                 runs_sent, items_stored, values_dropped);
        $display("Checked %0d sorted values under four idle/stall mixes.", results_checked);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
